FILE: rtl/core/laplacian_stencil_row_gen_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Laplacian stencil row generator
// Wraps concurrent assertions so that synthesis sees empty text.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_STENCIL_ROW_GEN_ASSERT_SVH
`define LAPLACIAN_STENCIL_ROW_GEN_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define LSRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsrg assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define LSRG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsrg assertion failed");
`else
`define LSRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LSRG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/lsrg_pkg.sv
// ----------------------------------------------------------------------------
// lsrg_pkg
// Widths, codes, stencil coefficients and shared types of the row generator.
// ----------------------------------------------------------------------------
package lsrg_pkg;

    localparam int C_ROW_W     = 12;
    localparam int C_SIZE_W    = 13;
    localparam int C_COEF_W    = 7;
    localparam int C_DIM_W     = 2;
    localparam int C_ORD_W     = 3;
    localparam int C_ALU_W     = 15;
    localparam int C_NTERM     = 9;
    localparam int C_TERM_W    = 4;
    localparam int C_CNT_W     = 4;
    localparam int C_SQ_W      = 2 * C_SIZE_W;
    localparam int C_PADDR_W   = 4;
    localparam int C_PDATA_W   = 32;
    localparam int C_MAX_NODES = 4096;

    localparam logic [C_DIM_W-1:0] C_DIM_LINE = 2'd1;
    localparam logic [C_DIM_W-1:0] C_DIM_GRID = 2'd2;
    localparam logic [C_ORD_W-1:0] C_ORD_2    = 3'd2;
    localparam logic [C_ORD_W-1:0] C_ORD_4    = 3'd4;

    // Term slots in ascending column order.
    localparam logic [C_TERM_W-1:0] T_UP2    = 4'd0;
    localparam logic [C_TERM_W-1:0] T_UP1    = 4'd1;
    localparam logic [C_TERM_W-1:0] T_LEFT2  = 4'd2;
    localparam logic [C_TERM_W-1:0] T_LEFT1  = 4'd3;
    localparam logic [C_TERM_W-1:0] T_CENTER = 4'd4;
    localparam logic [C_TERM_W-1:0] T_RIGHT1 = 4'd5;
    localparam logic [C_TERM_W-1:0] T_RIGHT2 = 4'd6;
    localparam logic [C_TERM_W-1:0] T_DOWN1  = 4'd7;
    localparam logic [C_TERM_W-1:0] T_DOWN2  = 4'd8;

    localparam logic signed [C_COEF_W-1:0] C_COEF_ZERO  = 7'sd0;
    localparam logic signed [C_COEF_W-1:0] C_COEF_DIAG  = 7'sd1;
    localparam logic signed [C_COEF_W-1:0] C_COEF_FAR   = -7'sd1;
    localparam logic signed [C_COEF_W-1:0] C_COEF_NEAR2 = 7'sd1;
    localparam logic signed [C_COEF_W-1:0] C_COEF_NEAR4 = 7'sd16;
    localparam logic signed [C_COEF_W-1:0] C_COEF_C1D2  = -7'sd2;
    localparam logic signed [C_COEF_W-1:0] C_COEF_C1D4  = -7'sd30;
    localparam logic signed [C_COEF_W-1:0] C_COEF_C2D2  = -7'sd4;
    localparam logic signed [C_COEF_W-1:0] C_COEF_C2D4  = -7'sd60;

    typedef enum logic [1:0] {
        R_DIMENSION     = 2'd0,
        R_STENCIL_ORDER = 2'd1,
        R_SIZE          = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [C_DIM_W-1:0]  dimension;
        logic [C_ORD_W-1:0]  stencil_order;
        logic [C_SIZE_W-1:0] size;
    } t_cfg;

    function automatic logic signed [C_COEF_W-1:0] f_coef(
        input logic [C_TERM_W-1:0] idx,
        input logic                two_d,
        input logic                fourth
    );
        logic signed [C_COEF_W-1:0] c;
        case (idx)
            T_UP2, T_LEFT2, T_RIGHT2, T_DOWN2: c = C_COEF_FAR;
            T_CENTER: begin
                if (two_d) begin
                    c = fourth ? C_COEF_C2D4 : C_COEF_C2D2;
                end else begin
                    c = fourth ? C_COEF_C1D4 : C_COEF_C1D2;
                end
            end
            default: c = fourth ? C_COEF_NEAR4 : C_COEF_NEAR2;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/lsrg_if.sv
// ----------------------------------------------------------------------------
// lsrg request and response channels
// Valid/ready channels carrying a row request and one stencil coefficient.
// ----------------------------------------------------------------------------
interface lsrg_req_if;
    logic                        valid;
    logic                        ready;
    logic [lsrg_pkg::C_ROW_W-1:0] row;

    modport source (output valid, output row, input ready);
    modport sink   (input valid, input row, output ready);
endinterface

interface lsrg_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [lsrg_pkg::C_ROW_W-1:0]         column;
    logic signed [lsrg_pkg::C_COEF_W-1:0] coefficient;
    logic                                last;
    logic                                error;

    modport source (output valid, output column, output coefficient, output last,
                    output error, input ready);
    modport sink   (input valid, input column, input coefficient, input last,
                    input error, output ready);
endinterface

FILE: rtl/core/lsrg_cfg.sv
// ----------------------------------------------------------------------------
// lsrg_cfg
// APB register file holding dimension, stencil order and size.
// ----------------------------------------------------------------------------
module lsrg_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsrg_pkg::C_PADDR_W-1:0]  paddr,
    input  logic [lsrg_pkg::C_PDATA_W-1:0]  pwdata,
    output logic [lsrg_pkg::C_PDATA_W-1:0]  prdata,
    output logic                            pready,
    output lsrg_pkg::t_cfg                  o_cfg
);
    import lsrg_pkg::*;

    t_cfg     r_cfg;
    logic     w_wr;
    t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dimension     <= C_DIM_LINE;
            r_cfg.stencil_order <= C_ORD_2;
            r_cfg.size          <= 13'd16;
        end else if (w_wr) begin
            case (w_idx)
                R_DIMENSION:     r_cfg.dimension     <= pwdata[C_DIM_W-1:0];
                R_STENCIL_ORDER: r_cfg.stencil_order <= pwdata[C_ORD_W-1:0];
                R_SIZE:          r_cfg.size          <= pwdata[C_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            R_DIMENSION:     prdata = C_PDATA_W'(r_cfg.dimension);
            R_STENCIL_ORDER: prdata = C_PDATA_W'(r_cfg.stencil_order);
            R_SIZE:          prdata = C_PDATA_W'(r_cfg.size);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/lsrg_alu.sv
// ----------------------------------------------------------------------------
// lsrg_alu
// Shared add/subtract unit for divider steps and column offsets.
// ----------------------------------------------------------------------------
module lsrg_alu (
    input  logic [lsrg_pkg::C_ALU_W-1:0] i_a,
    input  logic [lsrg_pkg::C_ALU_W-1:0] i_b,
    input  logic                         i_sub,
    output logic [lsrg_pkg::C_ALU_W-1:0] o_sum
);
    import lsrg_pkg::*;

    logic [C_ALU_W-1:0] w_b;

    assign w_b   = i_sub ? ~i_b : i_b;
    assign o_sum = i_a + w_b + C_ALU_W'(i_sub);

endmodule

FILE: rtl/core/laplacian_stencil_row_gen.sv
// ----------------------------------------------------------------------------
// laplacian_stencil_row_gen
// Emits the nonzero coefficients of one row of a finite-difference Laplacian.
// ----------------------------------------------------------------------------
// A request carries a row index; the block answers with one response per
// nonzero coefficient of that row, in ascending column order, and marks the
// final one with last. It handles one request at a time. In 1-D a request
// goes through one evaluation step and then emits its coefficients. In 2-D
// the row index is first split into grid coordinates by a restoring divider
// that retires one quotient bit per cycle on the shared adder. The same
// adder then forms each column index, one per cycle. Downstream stalls
// simply hold the emission sequence. An invalid mode, an oversized grid or
// an out-of-range row gives a single response with error and last set,
// column 0 and coefficient 0. Boundary nodes give a single 1 on the
// diagonal. Configuration registers (dimension at 0x0, stencil_order at
// 0x4, size at 0x8) must only be written while no request is in flight.
// ----------------------------------------------------------------------------
`include "laplacian_stencil_row_gen_assert.svh"

module laplacian_stencil_row_gen (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lsrg_req_if.sink                       i_req,
    lsrg_rsp_if.source                     o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lsrg_pkg::C_PADDR_W-1:0] paddr,
    input  logic [lsrg_pkg::C_PDATA_W-1:0] pwdata,
    output logic [lsrg_pkg::C_PDATA_W-1:0] prdata,
    output logic                           pready
);
    import lsrg_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_EVAL = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_cfg w_cfg;

    // Control state.
    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    // Working registers. After the divide r_dvd holds the y coordinate and
    // r_rem holds the x coordinate; in 1-D x is the row itself.
    logic [C_ROW_W-1:0]   r_row, n_row;
    logic [C_ROW_W-1:0]   r_dvd, n_dvd;
    logic [C_SIZE_W-1:0]  r_rem, n_rem;
    logic [C_CNT_W-1:0]   r_cnt, n_cnt;
    logic                 r_err, n_err;
    logic                 r_bnd, n_bnd;
    logic                 r_two_d, n_two_d;
    logic                 r_fourth, n_fourth;
    logic [C_NTERM-1:0]   r_mask, n_mask;

    // Output register.
    logic [C_ROW_W-1:0]         r_col, n_col;
    logic signed [C_COEF_W-1:0] r_coef, n_coef;
    logic                       r_last, n_last;
    logic                       r_oerr, n_oerr;

    // Shared adder hookup.
    logic [C_ALU_W-1:0] w_alu_a, w_alu_b, w_alu_sum;
    logic               w_alu_sub;

    // Request screening.
    logic [C_SQ_W-1:0]  w_sq;
    logic               w_dim_ok, w_ord_ok, w_grid, w_err_in;

    // Emission helpers.
    logic [C_TERM_W-1:0]   w_idx;
    logic [C_NTERM-1:0]    w_rest;
    logic [C_SIZE_W:0]     w_off;
    logic                  w_ge;
    logic                  w_load;

    // Assertion helpers.
    logic                  w_err_form;
    logic                  w_busy;

    lsrg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lsrg_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .i_sub (w_alu_sub),
        .o_sum (w_alu_sum)
    );

    // The mode and node-count checks run on the live registers as the request
    // is taken. A zero side length would give a meaningless quotient, so it is
    // caught here; a row past the last grid line is caught once the quotient
    // is known.
    assign w_dim_ok = (w_cfg.dimension == C_DIM_LINE) || (w_cfg.dimension == C_DIM_GRID);
    assign w_ord_ok = (w_cfg.stencil_order == C_ORD_2) || (w_cfg.stencil_order == C_ORD_4);
    assign w_grid   = (w_cfg.dimension == C_DIM_GRID);
    assign w_sq     = C_SQ_W'(w_cfg.size) * C_SQ_W'(w_cfg.size);

    always_comb begin
        if (!w_dim_ok || !w_ord_ok) begin
            w_err_in = 1'b1;
        end else if (w_grid) begin
            w_err_in = (w_sq > C_SQ_W'(C_MAX_NODES)) || (w_cfg.size == '0);
        end else begin
            w_err_in = (C_SQ_W'(w_cfg.size) > C_SQ_W'(C_MAX_NODES)) ||
                       ({1'b0, i_req.row} >= w_cfg.size);
        end
    end

    // The lowest pending term is the next to go out; it is last when nothing
    // remains above it.
    always_comb begin
        logic found;
        found = 1'b0;
        w_idx = T_CENTER;
        for (int i = 0; i < C_NTERM; i++) begin
            if (r_mask[i] && !found) begin
                found = 1'b1;
                w_idx = C_TERM_W'(i);
            end
        end
    end

    always_comb begin
        w_rest        = r_mask;
        w_rest[w_idx] = 1'b0;
    end

    // Magnitude of the column offset of each term; terms below the center
    // subtract it from the row.
    always_comb begin
        case (w_idx)
            T_UP2, T_DOWN2:     w_off = {w_cfg.size, 1'b0};
            T_UP1, T_DOWN1:     w_off = {1'b0, w_cfg.size};
            T_LEFT2, T_RIGHT2:  w_off = 14'd2;
            T_LEFT1, T_RIGHT1:  w_off = 14'd1;
            default:            w_off = '0;
        endcase
    end

    // During the divide the adder does the trial subtraction of the side
    // length from the shifted partial remainder; while emitting it forms the
    // column index.
    always_comb begin
        if (r_state == S_DIV) begin
            w_alu_a   = {1'b0, r_rem, r_dvd[C_ROW_W-1]};
            w_alu_b   = C_ALU_W'(w_cfg.size);
            w_alu_sub = 1'b1;
        end else begin
            w_alu_a   = C_ALU_W'(r_row);
            w_alu_b   = C_ALU_W'(w_off);
            w_alu_sub = (w_idx < T_CENTER);
        end
    end

    assign w_ge   = !w_alu_sum[C_ALU_W-1];
    assign w_load = (r_state == S_EMIT) && (!r_ovalid || o_rsp.ready);

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_row    = r_row;
        n_dvd    = r_dvd;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_err    = r_err;
        n_bnd    = r_bnd;
        n_two_d  = r_two_d;
        n_fourth = r_fourth;
        n_mask   = r_mask;
        n_col    = r_col;
        n_coef   = r_coef;
        n_last   = r_last;
        n_oerr   = r_oerr;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_row    = i_req.row;
                    n_two_d  = w_grid;
                    n_fourth = (w_cfg.stencil_order == C_ORD_4);
                    n_err    = w_err_in;
                    n_cnt    = '0;
                    if (!w_err_in && w_grid) begin
                        n_dvd   = i_req.row;
                        n_rem   = '0;
                        n_state = S_DIV;
                    end else begin
                        n_dvd   = '0;
                        n_rem   = C_SIZE_W'(i_req.row);
                        n_state = S_EVAL;
                    end
                end
            end
            S_DIV: begin
                n_rem = w_ge ? w_alu_sum[C_SIZE_W-1:0] : w_alu_a[C_SIZE_W-1:0];
                n_dvd = {r_dvd[C_ROW_W-2:0], w_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == C_CNT_W'(C_ROW_W - 1)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_two_d) begin
                    n_err = r_err || ({1'b0, r_dvd} >= w_cfg.size);
                    n_bnd = (r_rem == '0) || (r_rem == w_cfg.size - 1'b1) ||
                            (r_dvd == '0) || ({1'b0, r_dvd} == w_cfg.size - 1'b1);
                end else begin
                    n_bnd = (r_rem == '0) || (r_rem == w_cfg.size - 1'b1);
                end
                n_mask           = '0;
                n_mask[T_UP2]    = r_two_d && r_fourth && (r_dvd >= C_ROW_W'(2));
                n_mask[T_UP1]    = r_two_d;
                n_mask[T_LEFT2]  = r_fourth && (r_rem >= C_SIZE_W'(2));
                n_mask[T_LEFT1]  = 1'b1;
                n_mask[T_CENTER] = 1'b1;
                n_mask[T_RIGHT1] = 1'b1;
                n_mask[T_RIGHT2] = r_fourth &&
                                   (({1'b0, r_rem} + 14'd2) < {1'b0, w_cfg.size});
                n_mask[T_DOWN1]  = r_two_d;
                n_mask[T_DOWN2]  = r_two_d && r_fourth &&
                                   ((14'(r_dvd) + 14'd2) < {1'b0, w_cfg.size});
                // Errors and boundary nodes keep only the center term, so they give a single response.
                if (n_err || n_bnd) begin
                    n_mask           = '0;
                    n_mask[T_CENTER] = 1'b1;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_col    = r_err ? '0 : w_alu_sum[C_ROW_W-1:0];
                    if (r_err) begin
                        n_coef = C_COEF_ZERO;
                    end else if (r_bnd) begin
                        n_coef = C_COEF_DIAG;
                    end else begin
                        n_coef = f_coef(w_idx, r_two_d, r_fourth);
                    end
                    n_last = (w_rest == '0);
                    n_oerr = r_err;
                    n_mask = w_rest;
                    if (w_rest == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_err    <= n_err;
        r_bnd    <= n_bnd;
        r_two_d  <= n_two_d;
        r_fourth <= n_fourth;
        r_mask   <= n_mask;
        r_col    <= n_col;
        r_coef   <= n_coef;
        r_last   <= n_last;
        r_oerr   <= n_oerr;
    end

    // A new request is taken only between rows; the output register may still
    // hold the last response of the previous row.
    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.column      = r_col;
    assign o_rsp.coefficient = r_coef;
    assign o_rsp.last        = r_last;
    assign o_rsp.error       = r_oerr;

    // An error response is a lone zero at column 0; a taken request moves the
    // sequencer straight into the divide or the evaluation.
    assign w_err_form = o_rsp.last && (o_rsp.coefficient == C_COEF_ZERO) &&
                        (o_rsp.column == '0);
    assign w_busy     = (r_state == S_DIV) || (r_state == S_EVAL);

    `LSRG_ASSERT_IMP(a_err_single, i_clk, i_rst_n, o_rsp.valid && o_rsp.error, w_err_form)
    `LSRG_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_req.valid && i_req.ready, w_busy)
    `LSRG_ASSERT_IMP(a_emit_pending, i_clk, i_rst_n, r_state == S_EMIT, r_mask != '0)
    `LSRG_ASSERT_IMP(a_div_count, i_clk, i_rst_n, r_state == S_DIV, r_cnt < C_CNT_W'(C_ROW_W))
    `LSRG_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, w_load && (w_rest == '0), r_state == S_IDLE)

endmodule
